// ===== rtl/core/soc_pkg.sv =====
// Shared types, constants and helper functions of the substring occurrence counter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package soc_pkg;

   localparam int MAX_PATTERN_DEF = 48;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int WORD_COUNT      = 6;
   localparam int WORD_W          = 64;
   localparam int PAT_BYTES       = 48;
   localparam int PAT_IDX_W       = 6;
   localparam int LENGTH_W        = 6;
   localparam int CSR_INDEX_W     = 4;
   localparam int RSP_COUNT_W     = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_LENGTH    = 4'd6;
   localparam csr_index_type REG_CASE_FOLD = 4'd7;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } link_type;

   typedef struct packed {
      logic                   match_end;
      logic [RSP_COUNT_W-1:0] occurrence_count;
      logic                   end_of_data;
   } rsp_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      if (en && (c inside {[8'h41:8'h5A]})) begin
         return 8'(c + 8'd32);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/soc_ifs.sv =====
// Channel interfaces of the substring occurrence counter: request, response, register write.
// Depends on soc_pkg for field widths.
interface soc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface soc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            match_end;
   logic [soc_pkg::RSP_COUNT_W-1:0] occurrence_count;
   logic                            end_of_data;
   modport source (output valid, output match_end, output occurrence_count,
                   output end_of_data, input ready);
   modport sink (input valid, input match_end, input occurrence_count,
                 input end_of_data, output ready);
endinterface

interface soc_csr_if;
   logic                       valid;
   logic                       ready;
   soc_pkg::csr_index_type     index;
   logic [soc_pkg::WORD_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/soc_cfg.sv =====
// Register file of the counter and the aligned, folded pattern handed to the cell row.
// Depends on soc_pkg and soc_csr_if.
module soc_cfg #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   soc_csr_if.sink                              csr_chan,
   output logic [MAX_PATTERN-1:0][7:0]          align_ff,
   output logic [MAX_PATTERN-1:0]               active_ff,
   output logic                                 fold_ff,
   output logic [$clog2(MAX_PATTERN+1)-1:0]     len_ff,
   output logic                                 busy_ff
);
   localparam int LEN_W = $clog2(MAX_PATTERN+1);

   logic [soc_pkg::WORD_W-1:0]   word_ff [soc_pkg::WORD_COUNT];
   logic [soc_pkg::LENGTH_W-1:0] length_ff;
   logic                         case_fold_ff;
   logic [soc_pkg::WORD_COUNT*soc_pkg::WORD_W-1:0] pat_flat;
   logic [MAX_PATTERN-1:0][7:0]  align_in;
   logic [MAX_PATTERN-1:0]       active_in;
   logic [LEN_W-1:0]             len_in;
   logic                         write;

   assign csr_chan.ready = !reset;
   assign write          = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < soc_pkg::WORD_COUNT; w++) begin
            word_ff[w] <= '0;
         end
         length_ff    <= soc_pkg::LENGTH_W'(1);
         case_fold_ff <= 1'b1;
         busy_ff      <= 1'b1;
      end else begin
         busy_ff <= write;
         if (write) begin
            if (int'(csr_chan.index) < soc_pkg::WORD_COUNT) begin
               word_ff[csr_chan.index[2:0]] <= csr_chan.data;
            end else if (csr_chan.index == soc_pkg::REG_LENGTH) begin
               length_ff <= csr_chan.data[soc_pkg::LENGTH_W-1:0];
            end else if (csr_chan.index == soc_pkg::REG_CASE_FOLD) begin
               case_fold_ff <= csr_chan.data[0];
            end
         end
      end
   end

   always_comb begin
      for (int w = 0; w < soc_pkg::WORD_COUNT; w++) begin
         pat_flat[w*soc_pkg::WORD_W +: soc_pkg::WORD_W] = word_ff[w];
      end
   end

   always_comb begin
      int idx;
      idx = 0;
      if (int'(length_ff) > MAX_PATTERN) begin
         len_in = LEN_W'(MAX_PATTERN);
      end else begin
         len_in = LEN_W'(length_ff);
      end
      for (int k = 0; k < MAX_PATTERN; k++) begin
         idx          = int'(len_in) - 1 - k;
         active_in[k] = (k < int'(len_in));
         align_in[k]  = 8'h00;
         if (active_in[k] && (idx < soc_pkg::PAT_BYTES)) begin
            align_in[k] = soc_pkg::fold_byte(
               pat_flat[idx[soc_pkg::PAT_IDX_W-1:0]*8 +: 8], case_fold_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      align_ff  <= align_in;
      active_ff <= active_in;
      fold_ff   <= case_fold_ff;
      len_ff    <= len_in;
   end

endmodule

// ===== rtl/core/soc_cell.sv =====
// One window cell: holds one recent byte and compares the byte arriving from its neighbor.
// Depends on soc_pkg.
module soc_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              clear,
   input  soc_pkg::link_type link_in,
   input  logic [7:0]        align_byte,
   input  logic              active,
   input  logic              fold,
   output soc_pkg::link_type link_out,
   output logic              ok
);
   logic       valid_ff;
   logic [7:0] data_ff;

   assign ok = !active ||
               (link_in.valid && (soc_pkg::fold_byte(link_in.data, fold) == align_byte));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= link_in.valid && !clear;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= link_in.data;
      end
   end

   assign link_out = '{valid: valid_ff, data: data_ff};

endmodule

// ===== rtl/core/soc_chain.sv =====
// Row of window cells; each cell takes its neighbor's byte on every accepted request.
// Depends on soc_pkg and soc_cell.
module soc_chain #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic                        clear,
   input  logic [7:0]                  data_byte,
   input  logic [MAX_PATTERN-1:0][7:0] align,
   input  logic [MAX_PATTERN-1:0]      active,
   input  logic                        fold,
   output logic                        all_ok
);
   soc_pkg::link_type        link [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]   ok;

   assign link[0] = '{valid: 1'b1, data: data_byte};

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      soc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .clear      (clear),
         .link_in    (link[i]),
         .align_byte (align[i]),
         .active     (active[i]),
         .fold       (fold),
         .link_out   (link[i+1]),
         .ok         (ok[i])
      );
   end

   assign all_ok = &ok;

endmodule

// ===== rtl/core/substring_occurrence_counter_unit.sv =====
// Each response is written into a two-entry response queue when its request is accepted.
// Throughput: one request per cycle outside register reloads; the response queue keeps requests
// flowing while a response waits to be taken.
// Reset: clears the window, block and count, loads pattern length 1 with case folding;
// the request channel is held off in the cycle after reset and after each register write.
module substring_occurrence_counter_unit #(
   parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
   parameter int COUNT_BITS  = soc_pkg::COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   soc_req_if.sink    req_chan,
   soc_rsp_if.source  rsp_chan,
   soc_csr_if.sink    csr_chan
);
   localparam int          LEN_W      = $clog2(MAX_PATTERN+1);
   localparam logic [1:0]  QUEUE_FULL = 2'd2;

   logic [MAX_PATTERN-1:0][7:0] align;
   logic [MAX_PATTERN-1:0]      active;
   logic                        fold;
   logic [LEN_W-1:0]            len;
   logic                        cfg_busy;
   logic                        all_ok;
   logic                        accept;
   logic                        pop;
   logic                        hit;

   logic [LEN_W-1:0]      blocked_ff, blocked_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS+soc_pkg::RSP_COUNT_W-1:0] count_ext;
   soc_pkg::rsp_type      entry;
   soc_pkg::rsp_type      queue_ff [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            fill_ff;

   soc_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_chan  (csr_chan),
      .align_ff  (align),
      .active_ff (active),
      .fold_ff   (fold),
      .len_ff    (len),
      .busy_ff   (cfg_busy)
   );

   soc_chain #(.MAX_PATTERN(MAX_PATTERN)) u_chain (
      .clock     (clock),
      .reset     (reset),
      .shift     (accept),
      .clear     (req_chan.last_byte),
      .data_byte (req_chan.data_byte),
      .align     (align),
      .active    (active),
      .fold      (fold),
      .all_ok    (all_ok)
   );

   assign req_chan.ready = !reset && !cfg_busy && (fill_ff != QUEUE_FULL);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign hit            = all_ok && (len != '0) && (blocked_ff == '0);

   always_comb begin
      blocked_in = blocked_ff;
      count_in   = count_ff;
      if (blocked_ff != '0) begin
         blocked_in = blocked_ff - LEN_W'(1);
      end else if (hit) begin
         blocked_in = len - LEN_W'(1);
         if (count_ff != '1) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end
      count_ext              = {{soc_pkg::RSP_COUNT_W{1'b0}}, count_in};
      entry.match_end        = hit;
      entry.occurrence_count = count_ext[soc_pkg::RSP_COUNT_W-1:0];
      entry.end_of_data      = req_chan.last_byte;
      if (req_chan.last_byte) begin
         blocked_in = '0;
         count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         count_ff   <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         fill_ff    <= '0;
      end else begin
         if (accept) begin
            blocked_ff <= blocked_in;
            count_ff   <= count_in;
            wr_ptr_ff  <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(accept) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign rsp_chan.valid            = (fill_ff != '0);
   assign rsp_chan.match_end        = queue_ff[rd_ptr_ff].match_end;
   assign rsp_chan.occurrence_count = queue_ff[rd_ptr_ff].occurrence_count;
   assign rsp_chan.end_of_data      = queue_ff[rd_ptr_ff].end_of_data;

endmodule

// ===== rtl/core/soc_checker.sv =====
// Port-level checks of the substring occurrence counter, bound to the top level.
// Depends on soc_pkg and substring_occurrence_counter_unit.
module soc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_match_end,
   input logic [soc_pkg::RSP_COUNT_W-1:0] rsp_count,
   input logic                            rsp_end,
   input logic                            csr_valid,
   input logic                            csr_ready
);
   logic                            first_ff;
   logic [soc_pkg::RSP_COUNT_W-1:0] prev_count_ff;
   logic                            rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= 1'b1;
         prev_count_ff <= '0;
      end else if (rsp_take) begin
         first_ff      <= rsp_end;
         prev_count_ff <= rsp_count;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_cfg_holdoff: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request taken while pattern reloads");

   a_stream_start: assert property (@(posedge clock) disable iff (reset)
      rsp_take && first_ff |-> rsp_count == soc_pkg::RSP_COUNT_W'(rsp_match_end))
      else $error("count not restarted at stream start");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !first_ff |->
         (rsp_match_end ? (rsp_count == prev_count_ff + soc_pkg::RSP_COUNT_W'(1) ||
                           rsp_count == prev_count_ff)
                        : (rsp_count == prev_count_ff)))
      else $error("count moved without a match");

endmodule

bind substring_occurrence_counter_unit soc_checker u_soc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_match_end (rsp_chan.match_end),
   .rsp_count     (rsp_chan.occurrence_count),
   .rsp_end       (rsp_chan.end_of_data),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready)
);
